// ----- src/tlb_fully_assoc_lru_macros.svh -----
`ifndef TLB_FULLY_ASSOC_LRU_MACROS_SVH
`define TLB_FULLY_ASSOC_LRU_MACROS_SVH

// Assertion helpers; NO_ASSERTIONS compiles them away.
`ifndef NO_ASSERTIONS
`define TLB_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define TLB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TLB_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define TLB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- src/tlb_pkg.sv -----
package tlb_pkg;

    localparam int DEF_ENTRIES   = 16;
    localparam int DEF_PAGE_BITS = 20;
    localparam int DEF_ID_BITS   = 8;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_LOOKUP = 2'd0;
    localparam mode_t MODE_WRITE  = 2'd1;
    localparam mode_t MODE_REMOVE = 2'd2;

    typedef logic [2:0] lru_op_t;

    localparam lru_op_t LRU_NONE   = 3'd0;
    localparam lru_op_t LRU_TOUCH  = 3'd1;
    localparam lru_op_t LRU_DROP   = 3'd2;
    localparam lru_op_t LRU_INSERT = 3'd3;
    localparam lru_op_t LRU_FLUSH  = 3'd4;

    typedef struct packed {
        logic flush;
        logic set;
        logic clr;
    } cam_ctl_t;

endpackage

// ----- src/tlb_ifs.sv -----
interface tlb_req_if #(
    parameter int ID_BITS   = tlb_pkg::DEF_ID_BITS,
    parameter int PAGE_BITS = tlb_pkg::DEF_PAGE_BITS
);
    logic                 valid;
    logic                 ready;
    tlb_pkg::mode_t       mode;
    logic [ID_BITS-1:0]   proc_id;
    logic [PAGE_BITS-1:0] virt_page;
    logic [PAGE_BITS-1:0] phys_page;

    modport source (output valid, output mode, output proc_id, output virt_page,
                    output phys_page, input ready);
    modport sink   (input valid, input mode, input proc_id, input virt_page,
                    input phys_page, output ready);
endinterface

interface tlb_rsp_if #(
    parameter int PAGE_BITS = tlb_pkg::DEF_PAGE_BITS
);
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [PAGE_BITS-1:0] phys_out;

    modport source (output valid, output hit, output phys_out, input ready);
    modport sink   (input valid, input hit, input phys_out, output ready);
endinterface

// ----- src/tlb_tag_cam.sv -----
module tlb_tag_cam #(
    parameter int ENTRIES   = tlb_pkg::DEF_ENTRIES,
    parameter int PAGE_BITS = tlb_pkg::DEF_PAGE_BITS,
    parameter int IW        = $clog2(ENTRIES),
    parameter int CW        = $clog2(ENTRIES + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tlb_pkg::cam_ctl_t    ctl,
    input  logic [IW-1:0]        idx,
    input  logic [PAGE_BITS-1:0] tag,
    output logic [ENTRIES-1:0]   valid,
    output logic                 hit,
    output logic [IW-1:0]        match_idx,
    output logic                 free_any,
    output logic [IW-1:0]        free_idx,
    output logic [CW-1:0]        count
);
    import tlb_pkg::*;

    logic [ENTRIES-1:0]   valid_reg;
    logic [ENTRIES-1:0]   valid_next;
    logic [PAGE_BITS-1:0] tag_reg [ENTRIES];
    logic [ENTRIES-1:0]   match;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.flush)
        begin
            valid_next = '0;
        end
        if (ctl.set)
        begin
            valid_next[idx] = 1'b1;
        end
        if (ctl.clr)
        begin
            valid_next[idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.set)
        begin
            tag_reg[idx] <= tag;
        end
    end

    // parallel compare; lowest index wins on the match and free encoders
    always_comb
    begin
        match_idx = '0;
        free_idx  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            match[i] = valid_reg[i] && (tag_reg[i] == tag);
            if (match[i])
            begin
                match_idx = IW'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = IW'(i);
            end
        end
    end

    assign valid    = valid_reg;
    assign hit      = |match;
    assign free_any = ~&valid_reg;
    assign count    = CW'($countones(valid_reg));

endmodule

// ----- src/tlb_lru.sv -----
module tlb_lru #(
    parameter int ENTRIES = tlb_pkg::DEF_ENTRIES,
    parameter int IW      = $clog2(ENTRIES),
    parameter int CW      = $clog2(ENTRIES + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tlb_pkg::lru_op_t    op,
    input  logic [IW-1:0]       idx,
    input  logic [ENTRIES-1:0]  valid,
    input  logic [CW-1:0]       count,
    output logic [IW-1:0]       victim
);
    import tlb_pkg::*;

    // rank 0 is least recently used; invalid entries hold rank 0
    logic [IW-1:0] rank_reg  [ENTRIES];
    logic [IW-1:0] rank_next [ENTRIES];
    logic [IW-1:0] old_rank;
    logic [IW-1:0] top_rank;

    assign old_rank = rank_reg[idx];
    assign top_rank = IW'(count - CW'(1));

    always_comb
    begin
        rank_next = rank_reg;
        case (op)
            LRU_TOUCH, LRU_DROP:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (idx == IW'(i))
                    begin
                        rank_next[i] = (op == LRU_TOUCH) ? top_rank : '0;
                    end
                    else if (valid[i] && (rank_reg[i] > old_rank))
                    begin
                        rank_next[i] = rank_reg[i] - IW'(1);
                    end
                end
            end
            LRU_INSERT:
            begin
                rank_next[idx] = count[IW-1:0];
            end
            LRU_FLUSH:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    rank_next[i] = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            rank_reg <= rank_next;
        end
    end

    always_comb
    begin
        victim = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (rank_reg[i] == '0)
            begin
                victim = IW'(i);
            end
        end
    end

endmodule

// ----- src/tlb_fully_assoc_lru.sv -----
// A beat waits in the input register until the output register is free, then
// its result is registered there. Throughput: one beat per cycle unless rsp.ready
// stalls; the tag compare, rank update and page store all complete as it advances.
// Reset (rst_n, async low): owner id 0, all entries invalid, ranks 0;
// a beat is accepted right after reset is released, no clearing pass.
`include "tlb_fully_assoc_lru_macros.svh"

module tlb_fully_assoc_lru #(
    parameter int ENTRIES   = tlb_pkg::DEF_ENTRIES,
    parameter int PAGE_BITS = tlb_pkg::DEF_PAGE_BITS,
    parameter int ID_BITS   = tlb_pkg::DEF_ID_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    tlb_req_if.sink    req,
    tlb_rsp_if.source  rsp
);
    import tlb_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    mode_t                s1_mode_reg;
    logic [ID_BITS-1:0]   s1_pid_reg;
    logic [PAGE_BITS-1:0] s1_vp_reg;
    logic [PAGE_BITS-1:0] s1_pp_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 hit_reg;
    logic                 hit_next;
    logic [PAGE_BITS-1:0] phys_reg;

    logic [ID_BITS-1:0]   owner_reg;
    logic [ID_BITS-1:0]   owner_next;

    logic                 in_beat;
    logic                 advance;
    logic                 own;

    cam_ctl_t             cam_ctl;
    lru_op_t              lru_op;
    logic [IW-1:0]        ent_idx;
    logic                 mem_we;
    logic                 rd_hit;

    logic [ENTRIES-1:0]   valid;
    logic                 cam_hit;
    logic [IW-1:0]        match_idx;
    logic                 free_any;
    logic [IW-1:0]        free_idx;
    logic [CW-1:0]        count;
    logic [IW-1:0]        victim;

    logic [PAGE_BITS-1:0] page_mem [ENTRIES];

    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign in_beat   = req.valid && req.ready;

    assign s1_valid_next  = in_beat ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    assign own = (s1_pid_reg == owner_reg);

    always_comb
    begin
        cam_ctl    = '0;
        lru_op     = LRU_NONE;
        ent_idx    = match_idx;
        mem_we     = 1'b0;
        rd_hit     = 1'b0;
        hit_next   = 1'b0;
        owner_next = owner_reg;
        if (advance)
        begin
            case (s1_mode_reg)
                MODE_LOOKUP:
                begin
                    if (own && cam_hit)
                    begin
                        lru_op   = LRU_TOUCH;
                        rd_hit   = 1'b1;
                        hit_next = 1'b1;
                    end
                end
                MODE_WRITE:
                begin
                    mem_we = 1'b1;
                    if (!own)
                    begin
                        // new process: flush, then the write lands in slot 0
                        owner_next    = s1_pid_reg;
                        cam_ctl.flush = 1'b1;
                        cam_ctl.set   = 1'b1;
                        ent_idx       = '0;
                        lru_op        = LRU_FLUSH;
                    end
                    else if (cam_hit)
                    begin
                        lru_op   = LRU_TOUCH;
                        hit_next = 1'b1;
                    end
                    else if (free_any)
                    begin
                        cam_ctl.set = 1'b1;
                        ent_idx     = free_idx;
                        lru_op      = LRU_INSERT;
                    end
                    else
                    begin
                        cam_ctl.set = 1'b1;
                        ent_idx     = victim;
                        lru_op      = LRU_TOUCH;
                    end
                end
                MODE_REMOVE:
                begin
                    if (own && cam_hit)
                    begin
                        cam_ctl.clr = 1'b1;
                        lru_op      = LRU_DROP;
                        hit_next    = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    tlb_tag_cam #(
        .ENTRIES   (ENTRIES),
        .PAGE_BITS (PAGE_BITS)
    ) u_cam (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (cam_ctl),
        .idx       (ent_idx),
        .tag       (s1_vp_reg),
        .valid     (valid),
        .hit       (cam_hit),
        .match_idx (match_idx),
        .free_any  (free_any),
        .free_idx  (free_idx),
        .count     (count)
    );

    tlb_lru #(
        .ENTRIES (ENTRIES)
    ) u_lru (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (lru_op),
        .idx    (ent_idx),
        .valid  (valid),
        .count  (count),
        .victim (victim)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            owner_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            owner_reg     <= owner_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            s1_mode_reg <= req.mode;
            s1_pid_reg  <= req.proc_id;
            s1_vp_reg   <= req.virt_page;
            s1_pp_reg   <= req.phys_page;
        end
    end

    // physical page store, registered read straight into the result
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            page_mem[ent_idx] <= s1_pp_reg;
        end
        if (advance)
        begin
            hit_reg  <= hit_next;
            phys_reg <= rd_hit ? page_mem[match_idx] : '0;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.hit      = hit_reg;
    assign rsp.phys_out = phys_reg;

    `TLB_ASSERT_NEXT(a_owner_adopt, clk, rst_n, advance && (s1_mode_reg == MODE_WRITE),
        owner_reg == $past(s1_pid_reg), "write beat did not adopt its process id")
    `TLB_ASSERT_NEXT(a_write_fills, clk, rst_n, advance && (s1_mode_reg == MODE_WRITE),
        count != '0, "no valid entry after a write beat")
    `TLB_ASSERT_SAME(a_miss_zero, clk, rst_n, rsp.valid && !rsp.hit,
        rsp.phys_out == '0, "miss result carries a nonzero page")

endmodule
